[sv/frustum_box_cull_defines.svh]
// Assertion macros shared by the frustum box cull checker.
// No dependencies; pulled in by the checker file with `include.
`ifndef FRUSTUM_BOX_CULL_DEFINES_SVH
`define FRUSTUM_BOX_CULL_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fbc_pkg.sv]
// Shared constants and types for the frustum box cull block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fbc_pkg;

    // Plane set and register file
    localparam int PLANE_COUNT = 5;
    localparam int REG_COUNT   = 5;
    localparam int MASK_W      = 5;
    localparam int PLANE_W     = 3;
    localparam logic [PLANE_W-1:0] NO_PLANE = 3'd5;

    // Configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Arithmetic widths
    localparam int AXES    = 3;
    localparam int COORD_W = 16;
    localparam int Q_SHIFT = 14;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int SUM_W   = PROD_W + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [CFG_W-1:0] plane_t;

    // Box bounds, axis 0 is x, 1 is y, 2 is z
    typedef struct packed {
        coord_t [AXES-1:0] lo;
        coord_t [AXES-1:0] hi;
    } box_t;

endpackage

[sv/fbc_plane_lane.sv]
// One plane test lane: nearest-corner select, three products, sum and compare.
// Depends on fbc_pkg. Two register stages: products, then cull flag.
`timescale 1ns / 1ps

module fbc_plane_lane (
    input  logic            clk,
    input  fbc_pkg::plane_t plane,
    input  fbc_pkg::box_t   box,
    output logic            cull
);

    logic signed [fbc_pkg::PROD_W-1:0]  prod_next [fbc_pkg::AXES];
    logic signed [fbc_pkg::PROD_W-1:0]  prod_reg  [fbc_pkg::AXES];
    logic signed [fbc_pkg::COORD_W-1:0] dist_reg;
    logic signed [fbc_pkg::SUM_W-1:0]   sum_next;
    logic signed [fbc_pkg::SUM_W-1:0]   thresh_next;
    logic                               cull_reg;

    // Corner nearest along the normal: negative component takes the minimum
    always_comb
    begin
        for (int a = 0; a < fbc_pkg::AXES; a++)
        begin
            logic signed [fbc_pkg::COORD_W-1:0] n;
            logic signed [fbc_pkg::COORD_W-1:0] c;
            n = $signed(plane[a*fbc_pkg::COORD_W +: fbc_pkg::COORD_W]);
            c = n[fbc_pkg::COORD_W-1] ? $signed(box.lo[a]) : $signed(box.hi[a]);
            prod_next[a] = n * c;
        end
    end

    // Product stage
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < fbc_pkg::AXES; a++)
        begin
            prod_reg[a] <= prod_next[a];
        end
        dist_reg <= $signed(plane[fbc_pkg::CFG_W-1 -: fbc_pkg::COORD_W]);
    end

    // Exact dot product against distance scaled to Q1.14
    always_comb
    begin
        sum_next = fbc_pkg::SUM_W'(prod_reg[0]) + fbc_pkg::SUM_W'(prod_reg[1])
                 + fbc_pkg::SUM_W'(prod_reg[2]);
        thresh_next = fbc_pkg::SUM_W'(dist_reg) <<< fbc_pkg::Q_SHIFT;
    end

    // Compare stage
    always_ff @(posedge clk)
    begin
        cull_reg <= (sum_next < thresh_next);
    end

    assign cull = cull_reg;

endmodule

[sv/frustum_box_cull.sv]
// Frustum box cull: an accepted start runs through the s1, s2 and s3 valid registers to the done strobe register.
// Throughput is one box per clock; busy is never raised and results cannot stall.
// Stages: input register, per-plane products, per-plane compare, select and output.
// Reset clears all plane registers to zero (no plane culls) and empties the pipeline.
// Depends on fbc_pkg and fbc_plane_lane.
`timescale 1ns / 1ps

module frustum_box_cull (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [fbc_pkg::COORD_W-1:0] min_x,
    input  logic signed [fbc_pkg::COORD_W-1:0] min_y,
    input  logic signed [fbc_pkg::COORD_W-1:0] min_z,
    input  logic signed [fbc_pkg::COORD_W-1:0] max_x,
    input  logic signed [fbc_pkg::COORD_W-1:0] max_y,
    input  logic signed [fbc_pkg::COORD_W-1:0] max_z,
    input  logic [fbc_pkg::MASK_W-1:0]         plane_mask,
    input  logic [fbc_pkg::PLANE_W-1:0]        cached_plane,
    input  logic                              cfg_write,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbc_pkg::CFG_W-1:0]          cfg_data,
    output logic                              done,
    output logic                              culled,
    output logic [fbc_pkg::PLANE_W-1:0]        new_cached_plane
);

    fbc_pkg::plane_t                  plane_reg [fbc_pkg::REG_COUNT];
    fbc_pkg::plane_t                  lane_plane [fbc_pkg::PLANE_COUNT];
    logic [fbc_pkg::PLANE_COUNT-1:0]  cull_vec;
    logic [fbc_pkg::PLANE_COUNT-1:0]  en_vec;

    logic                             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    fbc_pkg::box_t                    s1_box_reg;
    logic [fbc_pkg::MASK_W-1:0]       s1_mask_reg, s2_mask_reg, s3_mask_reg;
    logic [fbc_pkg::PLANE_W-1:0]      s1_cached_reg, s2_cached_reg, s3_cached_reg;

    logic                             done_reg;
    logic                             culled_reg, culled_next;
    logic [fbc_pkg::PLANE_W-1:0]      ncp_reg, ncp_next;

    // No stall source in the pipeline
    assign busy = 1'b0;

    // Plane register file; writes beyond the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < fbc_pkg::REG_COUNT; r++)
            begin
                plane_reg[r] <= '0;
            end
        end
        else if (cfg_write)
        begin
            for (int r = 0; r < fbc_pkg::REG_COUNT; r++)
            begin
                if (cfg_index == fbc_pkg::CFG_IDX_W'(r))
                begin
                    plane_reg[r] <= cfg_data;
                end
            end
        end
    end

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        s1_box_reg.lo  <= {min_z, min_y, min_x};
        s1_box_reg.hi  <= {max_z, max_y, max_x};
        s1_mask_reg    <= plane_mask;
        s1_cached_reg  <= cached_plane;
        s2_mask_reg    <= s1_mask_reg;
        s2_cached_reg  <= s1_cached_reg;
        s3_mask_reg    <= s2_mask_reg;
        s3_cached_reg  <= s2_cached_reg;
        culled_reg     <= culled_next;
        ncp_reg        <= ncp_next;
    end

    // Plane lanes; planes without a register or mask bit never cull or are never enabled
    for (genvar p = 0; p < fbc_pkg::PLANE_COUNT; p++)
    begin : g_lane
        if (p < fbc_pkg::REG_COUNT)
        begin : g_reg
            assign lane_plane[p] = plane_reg[p];
        end
        else
        begin : g_zero
            assign lane_plane[p] = '0;
        end

        if (p < fbc_pkg::MASK_W)
        begin : g_mask
            assign en_vec[p] = s3_mask_reg[p];
        end
        else
        begin : g_nomask
            assign en_vec[p] = 1'b0;
        end

        fbc_plane_lane u_lane (
            .clk   (clk),
            .plane (lane_plane[p]),
            .box   (s1_box_reg),
            .cull  (cull_vec[p])
        );
    end

    // Cached plane first, then lowest enabled plane that culls
    always_comb
    begin
        logic have_cached;
        logic cached_hit;
        logic found;
        logic [fbc_pkg::PLANE_W-1:0] idx;
        have_cached = (s3_cached_reg != fbc_pkg::NO_PLANE)
                   && (s3_cached_reg < fbc_pkg::PLANE_W'(fbc_pkg::PLANE_COUNT));
        cached_hit  = 1'b0;
        found       = 1'b0;
        idx         = fbc_pkg::NO_PLANE;
        for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++)
        begin
            if (have_cached && (s3_cached_reg == fbc_pkg::PLANE_W'(p)) && cull_vec[p])
            begin
                cached_hit = 1'b1;
            end
        end
        for (int p = fbc_pkg::PLANE_COUNT - 1; p >= 0; p--)
        begin
            if (en_vec[p] && cull_vec[p]
                && !(have_cached && (s3_cached_reg == fbc_pkg::PLANE_W'(p))))
            begin
                found = 1'b1;
                idx   = fbc_pkg::PLANE_W'(p);
            end
        end
        if (cached_hit)
        begin
            culled_next = 1'b1;
            ncp_next    = s3_cached_reg;
        end
        else if (found)
        begin
            culled_next = 1'b1;
            ncp_next    = idx;
        end
        else
        begin
            culled_next = 1'b0;
            ncp_next    = fbc_pkg::NO_PLANE;
        end
    end

    assign done             = done_reg;
    assign culled           = culled_reg;
    assign new_cached_plane = ncp_reg;

endmodule

[sv/fbc_checker.sv]
// Port-level checker for frustum_box_cull, attached by the bind at the end.
// Depends on fbc_pkg and frustum_box_cull_defines.svh.
`timescale 1ns / 1ps
`include "frustum_box_cull_defines.svh"

module fbc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic                         culled,
    input logic [fbc_pkg::PLANE_W-1:0]  new_cached_plane
);

    // Every accepted word comes out as a done result
    `FBC_ASSERT_IMPL(a_latency, clk, rst_n, start && !busy, ##4 done, "result missing")

    // No result without an earlier accepted word
    `FBC_ASSERT_IMPL(a_no_extra, clk, rst_n, done, $past(start && !busy, 4), "spurious result")

    // A kept box reports no plane
    `FBC_ASSERT_IMPL(a_kept_none, clk, rst_n, done && !culled,
        new_cached_plane == fbc_pkg::NO_PLANE, "kept box names a plane")

    // A culled box names a real plane
    `FBC_ASSERT_IMPL(a_cull_plane, clk, rst_n, done && culled,
        new_cached_plane < fbc_pkg::PLANE_W'(fbc_pkg::PLANE_COUNT), "bad cull plane")

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .culled           (culled),
    .new_cached_plane (new_cached_plane)
);

[tb/sv/fbc_cull_checker.sv]
// Checker for the frustum box cull block: predicts the verdict of every accepted box
// from its own copy of the plane registers and compares the done words in order.
// Depends on fbc_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps

module fbc_cull_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic signed [fbc_pkg::COORD_W-1:0] min_x,
    input  logic signed [fbc_pkg::COORD_W-1:0] min_y,
    input  logic signed [fbc_pkg::COORD_W-1:0] min_z,
    input  logic signed [fbc_pkg::COORD_W-1:0] max_x,
    input  logic signed [fbc_pkg::COORD_W-1:0] max_y,
    input  logic signed [fbc_pkg::COORD_W-1:0] max_z,
    input  logic [fbc_pkg::MASK_W-1:0]         plane_mask,
    input  logic [fbc_pkg::PLANE_W-1:0]        cached_plane,
    input  logic                               cfg_write,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               done,
    input  logic                               culled,
    input  logic [fbc_pkg::PLANE_W-1:0]        new_cached_plane,
    output int                                 mismatches,
    output int                                 outstanding
);
    import fbc_pkg::*;

    typedef struct {
        logic               hit;
        logic [PLANE_W-1:0] plane;
    } verdict_t;

    plane_t   plane_regs [REG_COUNT];
    verdict_t expected_verdicts [$];
    int       fail_count = 0;

    // True when the nearest corner along the normal lies behind the plane.
    // Planes without a register act as all zero and never reject.
    function automatic logic plane_rejects(int idx, box_t b);
        longint dot;
        longint n;
        longint corner;
        longint distance;
        plane_t p;
        dot = 0;
        p = (idx < REG_COUNT) ? plane_regs[idx] : '0;
        for (int a = 0; a < AXES; a++)
        begin
            n = longint'($signed(p[COORD_W*a +: COORD_W]));
            corner = (n < 0) ? longint'($signed(b.lo[a])) : longint'($signed(b.hi[a]));
            dot += n * corner;
        end
        distance = longint'($signed(p[CFG_W-1 -: COORD_W]));
        return dot < (distance <<< Q_SHIFT);
    endfunction

    // Cached plane first, then the masked planes in ascending order, cached one skipped.
    function automatic verdict_t predict_verdict(box_t b, logic [MASK_W-1:0] mask,
                                                 logic [PLANE_W-1:0] cached);
        verdict_t v;
        logic     usable;
        usable = (cached < PLANE_COUNT);
        v.hit = 1'b0;
        v.plane = NO_PLANE;
        if (usable && plane_rejects(int'(cached), b))
        begin
            v.hit = 1'b1;
            v.plane = cached;
            return v;
        end
        for (int i = 0; i < PLANE_COUNT && i < MASK_W; i++)
        begin
            if (!v.hit && mask[i] && !(usable && i == int'(cached)) && plane_rejects(i, b))
            begin
                v.hit = 1'b1;
                v.plane = PLANE_W'(i);
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        box_t     b;
        verdict_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                plane_regs[i] = '0;
            expected_verdicts.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            // accepted box: predict with the planes as they stood before this edge
            if (start && !busy)
            begin
                b.lo = {min_z, min_y, min_x};
                b.hi = {max_z, max_y, max_x};
                expected_verdicts.push_back(predict_verdict(b, plane_mask, cached_plane));
            end

            // result word: compare with the oldest prediction
            if (done)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result word with no box pending: culled %0d new_cached_plane %0d",
                           culled, new_cached_plane);
                    fail_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (culled !== want.hit)
                    begin
                        $error("culled: expected %0d, got %0d", want.hit, culled);
                        fail_count++;
                    end
                    if (new_cached_plane !== want.plane)
                    begin
                        $error("new_cached_plane: expected %0d, got %0d",
                               want.plane, new_cached_plane);
                        fail_count++;
                    end
                end
            end

            // register writes; indexes past the last plane are dropped
            if (cfg_write && cfg_index < REG_COUNT)
                plane_regs[cfg_index] = cfg_data;

            mismatches <= fail_count;
            outstanding <= expected_verdicts.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// Top of the frustum box cull testbench: clock, reset, plane setup and box stimulus.
// Depends on fbc_pkg, frustum_box_cull and fbc_cull_checker, which checks every result word.
`timescale 1ns / 1ps

module tb;
    import fbc_pkg::*;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 155;

    localparam coord_t C_MIN = -16'sd32768;
    localparam coord_t C_MAX = 16'sd32767;

    localparam logic [MASK_W-1:0] MASK_NONE     = '0;
    localparam logic [MASK_W-1:0] MASK_ALL      = '1;
    localparam logic [MASK_W-1:0] MASK_LEFT     = 5'b00001;
    localparam logic [MASK_W-1:0] MASK_NOT_LEFT = 5'b11110;

    // Directed plane set, one role per register
    localparam logic [PLANE_W-1:0] PL_LEFT  = 3'd0;
    localparam logic [PLANE_W-1:0] PL_RIGHT = 3'd1;
    localparam logic [PLANE_W-1:0] PL_TILT  = 3'd2;
    localparam logic [PLANE_W-1:0] PL_WILD  = 3'd3;
    localparam logic [PLANE_W-1:0] PL_FLOOR = 3'd4;
    // cached values past the plane set, treated as none
    localparam logic [PLANE_W-1:0] PL_BEYOND_LO = 3'd6;
    localparam logic [PLANE_W-1:0] PL_BEYOND_HI = 3'd7;

    typedef enum int {
        SET_REAL,
        SET_FULL,
        SET_MOST_NEG,
        SET_MOST_POS,
        SET_ZERO,
        SET_MIXED
    } plane_set_e;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    coord_t             min_x, min_y, min_z, max_x, max_y, max_z;
    logic [MASK_W-1:0]  plane_mask;
    logic [PLANE_W-1:0] cached_plane;
    logic               cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    plane_t             cfg_data;
    logic               done;
    logic               culled;
    logic [PLANE_W-1:0] new_cached_plane;
    int                 mismatches;
    int                 outstanding;
    int                 cycles = 0;

    frustum_box_cull dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .min_x            (min_x),
        .min_y            (min_y),
        .min_z            (min_z),
        .max_x            (max_x),
        .max_y            (max_y),
        .max_z            (max_z),
        .plane_mask       (plane_mask),
        .cached_plane     (cached_plane),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .culled           (culled),
        .new_cached_plane (new_cached_plane)
    );

    fbc_cull_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .min_x            (min_x),
        .min_y            (min_y),
        .min_z            (min_z),
        .max_x            (max_x),
        .max_y            (max_y),
        .max_z            (max_z),
        .plane_mask       (plane_mask),
        .cached_plane     (cached_plane),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .culled           (culled),
        .new_cached_plane (new_cached_plane),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic plane_t pack_plane(coord_t nx, coord_t ny, coord_t nz, coord_t distance);
        return {distance, nz, ny, nx};
    endfunction

    function automatic coord_t clamp16(int v);
        if (v > 32767)
            return C_MAX;
        if (v < -32768)
            return C_MIN;
        return coord_t'(v);
    endfunction

    function automatic coord_t rand_q14();
        return coord_t'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic plane_t random_plane(plane_set_e setting);
        case (setting)
            SET_REAL:     return pack_plane(rand_q14(), rand_q14(), rand_q14(),
                                            coord_t'(int'($urandom_range(0, 4000)) - 2000));
            SET_FULL:     return {$urandom, $urandom};
            SET_MOST_NEG: return {4{16'h8000}};
            SET_MOST_POS: return {4{16'h7FFF}};
            SET_ZERO:     return '0;
            default:      return ($urandom_range(0, 1) != 0) ? random_plane(SET_REAL)
                                                             : random_plane(SET_FULL);
        endcase
    endfunction

    task automatic write_plane(int idx, plane_t value);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // All five planes plus one write past the register file, which must be dropped
    task automatic load_planes(plane_set_e setting);
        for (int i = 0; i < REG_COUNT; i++)
            write_plane(i, random_plane(setting));
        write_plane(REG_COUNT + int'($urandom_range(0, 2)), {$urandom, $urandom});
        cfg_write <= 1'b0;
    endtask

    // One box word; holds start until accepted, then idles for gap cycles
    task automatic send_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy,
                            coord_t hz, logic [MASK_W-1:0] mask,
                            logic [PLANE_W-1:0] cached, int gap);
        min_x        <= lx;
        min_y        <= ly;
        min_z        <= lz;
        max_x        <= hx;
        max_y        <= hy;
        max_z        <= hz;
        plane_mask   <= mask;
        cached_plane <= cached;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly well-formed boxes near the planes, plus noise, inverted and extreme boxes
    task automatic send_random(int gap);
        int     kind;
        int     c;
        int     e;
        coord_t u;
        coord_t w;
        coord_t lo [AXES];
        coord_t hi [AXES];
        coord_t corners [4];
        logic [PLANE_W-1:0] cached;
        corners = '{C_MIN, C_MAX, 16'sd0, -16'sd1};
        kind = $urandom_range(0, 9);
        for (int a = 0; a < AXES; a++)
        begin
            if (kind <= 4)
            begin
                c = int'($urandom_range(0, 6000)) - 3000;
                e = $urandom_range(0, 400);
                lo[a] = clamp16(c - e);
                hi[a] = clamp16(c + e);
            end
            else if (kind <= 6)
            begin
                c = int'($urandom_range(0, 65535)) - 32768;
                e = $urandom_range(0, 4000);
                lo[a] = clamp16(c - e);
                hi[a] = clamp16(c + e);
            end
            else if (kind == 7)
            begin
                lo[a] = coord_t'($urandom);
                hi[a] = coord_t'($urandom);
            end
            else if (kind == 8)
            begin
                u = coord_t'($urandom);
                w = coord_t'($urandom);
                lo[a] = (u > w) ? u : w;
                hi[a] = (u > w) ? w : u;
            end
            else
            begin
                lo[a] = corners[$urandom_range(0, 3)];
                hi[a] = corners[$urandom_range(0, 3)];
            end
        end
        cached = ($urandom_range(0, 9) < 7) ? PLANE_W'($urandom_range(0, 5))
                                            : PLANE_W'($urandom_range(0, 7));
        send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], MASK_W'($urandom), cached, gap);
    endtask

    // Wait for every predicted word, then let the pipeline empty
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        min_x        <= '0;
        min_y        <= '0;
        min_z        <= '0;
        max_x        <= '0;
        max_y        <= '0;
        max_z        <= '0;
        plane_mask   <= '0;
        cached_plane <= NO_PLANE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // planes still at reset: nothing may be culled
        send_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, MASK_ALL, PL_LEFT, 0);
        send_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, MASK_ALL, NO_PLANE, 3);
        send_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, MASK_ALL, PL_BEYOND_HI, 0);
        settle();

        // directed planes: x walls, a tilted plane, an extreme plane and a floor
        write_plane(PL_LEFT,  pack_plane(16384, 0, 0, 100));
        write_plane(PL_RIGHT, pack_plane(-16384, 0, 0, -200));
        write_plane(PL_TILT,  pack_plane(0, 11585, -11585, -50));
        write_plane(PL_WILD,  pack_plane(C_MIN, C_MAX, C_MIN, C_MAX));
        write_plane(PL_FLOOR, pack_plane(0, 0, 16384, 0));
        write_plane(PL_BEYOND_LO, '1);
        write_plane(PL_BEYOND_HI, {4{16'h8000}});
        cfg_write <= 1'b0;

        send_box(0, 0, 0, 50, 10, 10, MASK_LEFT, NO_PLANE, $urandom_range(0, 9));
        // cached plane culls with its mask bit clear
        send_box(0, 0, 0, 50, 10, 10, MASK_NONE, PL_LEFT, $urandom_range(0, 9));
        send_box(300, 0, 0, 400, 10, 10, MASK_ALL, NO_PLANE, 0);
        // cached plane misses and is skipped in the search
        send_box(300, 0, 0, 400, 10, 10, MASK_ALL, PL_LEFT, 0);
        send_box(300, 0, 0, 400, 10, 10, MASK_NONE, PL_RIGHT, $urandom_range(0, 9));
        send_box(300, 0, 0, 400, 10, 10, MASK_NONE, PL_BEYOND_LO, 0);
        send_box(0, 0, 0, 50, 10, 10, MASK_LEFT, PL_BEYOND_HI, $urandom_range(0, 9));
        send_box(100, 0, -20, 150, 10, -5, MASK_ALL, NO_PLANE, 0);
        // inverted box
        send_box(400, 50, 50, -400, -50, -50, MASK_ALL, NO_PLANE, 0);
        send_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, MASK_ALL, NO_PLANE, 1);
        send_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, MASK_ALL, PL_WILD, 0);
        send_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, MASK_ALL, PL_FLOOR, 0);
        send_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, MASK_ALL, PL_TILT, 2);
        send_box(0, 0, 0, 50, 10, 10, MASK_NONE, NO_PLANE, 0);
        send_box(0, 0, -10, 50, 10, -1, MASK_NOT_LEFT, NO_PLANE, 0);
        settle();

        // random phases, each with a new plane setting; odd phases run back to back
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            load_planes(plane_set_e'(phase % 6));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random((phase % 2 == 1) ? 0 : int'($urandom_range(0, 9)));
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[frustum_box_cull.f]
+incdir+sv
sv/fbc_pkg.sv
sv/fbc_plane_lane.sv
sv/frustum_box_cull.sv
sv/fbc_checker.sv
tb/sv/fbc_cull_checker.sv
tb/sv/tb.sv
